// ===== src/b2a_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package b2a_pkg;

    // Width of the number to convert and of one ASCII character.
    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 7;
    localparam int DIGIT_W    = 4;

    // Ten decimal digits cover any 32-bit value; hexadecimal needs eight.
    localparam int NUM_CELLS  = 10;
    localparam int HEX_DIGITS = VALUE_W / DIGIT_W;

    localparam int CNT_W  = $clog2(VALUE_W);
    localparam int LEFT_W = $clog2(NUM_CELLS + 1);

    // A decimal digit at or above five is corrected by three before it doubles.
    localparam logic [DIGIT_W-1:0] DABBLE_MIN = DIGIT_W'(5);
    localparam logic [DIGIT_W-1:0] DABBLE_ADD = DIGIT_W'(3);

    localparam logic [CHAR_W-1:0] GLYPHS [16] = '{
        CHAR_W'(8'h30), CHAR_W'(8'h31), CHAR_W'(8'h32), CHAR_W'(8'h33),
        CHAR_W'(8'h34), CHAR_W'(8'h35), CHAR_W'(8'h36), CHAR_W'(8'h37),
        CHAR_W'(8'h38), CHAR_W'(8'h39), CHAR_W'(8'h41), CHAR_W'(8'h42),
        CHAR_W'(8'h43), CHAR_W'(8'h44), CHAR_W'(8'h45), CHAR_W'(8'h46)
    };

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_DABBLE,
        CELL_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== src/b2a_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One digit of the conversion row.
module b2a_cell (
    input  logic                        i_clk,
    input  b2a_pkg::t_cell_ctl          i_ctl,
    input  logic                        i_bit,
    input  logic [b2a_pkg::DIGIT_W-1:0] i_load,
    input  logic [b2a_pkg::DIGIT_W-1:0] i_digit_lo,
    output logic                        o_carry,
    output logic [b2a_pkg::DIGIT_W-1:0] o_digit
);
    import b2a_pkg::*;

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    logic [DIGIT_W-1:0] w_adj;

    always_comb begin
        w_adj = (r_digit >= DABBLE_MIN) ? r_digit + DABBLE_ADD : r_digit;
    end

    // The top bit of the corrected digit moves up into the next cell.
    assign o_carry = w_adj[DIGIT_W-1];
    assign o_digit = r_digit;

    always_comb begin
        case (i_ctl.op)
            CELL_HOLD:   n_digit = r_digit;
            CELL_LOAD:   n_digit = i_load;
            CELL_DABBLE: n_digit = {w_adj[DIGIT_W-2:0], i_bit};
            CELL_SHIFT:  n_digit = i_digit_lo;
            default:     n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

`default_nettype wire

// ===== src/binary_to_ascii_digits.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Converts a 32-bit unsigned number into its ASCII digits, most significant
// first, without leading zeros, in decimal or upper-case hexadecimal. An item
// is taken when start is high and busy is low. The characters then appear on
// o_ascii_char, one per o_valid pulse, and o_last marks the final one; zero
// gives the single character '0'. The receiver cannot stall the block, so it
// must take every character in the cycle it is shown. For a decimal item the
// row of ten digit cells first shifts the value in one bit a cycle with the
// add-three correction, then the cells shift their digits toward the output,
// one digit a cycle; busy stays high throughout. A hexadecimal item loads
// its nibbles straight into the cells and only shifts them out. Leading
// zeros use their shift cycle but raise no strobe. The last character is
// shown in the cycle in which busy falls, so the next item can be started
// while it is taken.
module binary_to_ascii_digits (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [b2a_pkg::VALUE_W-1:0] i_value,
    input  logic                        i_base_hex,
    output logic                        o_valid,
    output logic [b2a_pkg::CHAR_W-1:0]  o_ascii_char,
    output logic                        o_last
);
    import b2a_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic [VALUE_W-1:0]  r_value;
    logic [CNT_W-1:0]    r_cnt;
    logic [LEFT_W-1:0]   r_left;
    logic                r_lead;
    logic                r_valid;
    logic [CHAR_W-1:0]   r_char;
    logic                r_last;

    t_cell_ctl           w_ctl;
    logic [NUM_CELLS:0]  w_carry;
    logic [DIGIT_W-1:0]  w_digit [NUM_CELLS];
    logic [DIGIT_W-1:0]  w_top;
    logic                w_show;
    logic                w_accept;

    assign w_accept = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);

    // The value enters the row of cells most significant bit first.
    assign w_carry[0] = r_value[VALUE_W-1];

    // Cell NUM_CELLS-1 holds the most significant digit and feeds the output.
    genvar k;
    generate
        for (k = 0; k < NUM_CELLS; k++) begin : g_cell
            logic [DIGIT_W-1:0] w_load;
            logic [DIGIT_W-1:0] w_lo;

            // Hexadecimal nibbles go into the upper eight cells; decimal
            // conversion starts from all zeros.
            if (k >= NUM_CELLS - HEX_DIGITS) begin : g_hex
                assign w_load = i_base_hex ?
                    i_value[(k - (NUM_CELLS - HEX_DIGITS)) * DIGIT_W +: DIGIT_W] : '0;
            end else begin : g_dec
                assign w_load = '0;
            end

            if (k == 0) begin : g_first
                assign w_lo = '0;
            end else begin : g_next
                assign w_lo = w_digit[k-1];
            end

            b2a_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_bit      (w_carry[k]),
                .i_load     (w_load),
                .i_digit_lo (w_lo),
                .o_carry    (w_carry[k+1]),
                .o_digit    (w_digit[k])
            );
        end
    endgenerate

    assign w_top = w_digit[NUM_CELLS-1];

    // A digit is shown once a nonzero digit has appeared, and the final digit
    // is always shown so that zero still prints as '0'.
    assign w_show = !r_lead || (w_top != '0) || (r_left == LEFT_W'(1));

    always_comb begin
        case (r_state)
            S_IDLE:  w_ctl.op = w_accept ? CELL_LOAD : CELL_HOLD;
            S_CONV:  w_ctl.op = CELL_DABBLE;
            S_EMIT:  w_ctl.op = CELL_SHIFT;
            default: w_ctl.op = CELL_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_lead  <= 1'b1;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_value <= i_value;
                        r_cnt   <= '0;
                        r_lead  <= 1'b1;
                        if (i_base_hex) begin
                            r_left  <= LEFT_W'(HEX_DIGITS);
                            r_state <= S_EMIT;
                        end else begin
                            r_left  <= LEFT_W'(NUM_CELLS);
                            r_state <= S_CONV;
                        end
                    end
                end
                S_CONV: begin
                    r_value <= {r_value[VALUE_W-2:0], 1'b0};
                    r_cnt   <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_valid <= w_show;
                    r_char  <= GLYPHS[w_top];
                    r_last  <= (r_left == LEFT_W'(1));
                    r_lead  <= r_lead && !w_show;
                    r_left  <= r_left - LEFT_W'(1);
                    if (r_left == LEFT_W'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_valid;
    assign o_ascii_char = r_char;
    assign o_last       = r_last;

`ifndef SYNTHESIS
    // The final character of an item is shown exactly when the block frees up.
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !busy)
        else $error("last character shown while still busy");

    // No character leaves while bits are still being shifted in.
    a_quiet_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CONV |-> !o_valid)
        else $error("character shown during conversion");

    // Ten decimal digits hold any 32-bit value, so nothing leaves the top cell.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CONV |-> !w_carry[NUM_CELLS])
        else $error("decimal digit row overflowed");

    // Every character is a decimal digit or an upper-case hex letter.
    a_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_ascii_char >= CHAR_W'(8'h30) && o_ascii_char <= CHAR_W'(8'h39))
                 || (o_ascii_char >= CHAR_W'(8'h41) && o_ascii_char <= CHAR_W'(8'h46)))
        else $error("character outside the digit set");

    // A hexadecimal item never needs the conversion phase.
    a_hex_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_base_hex |=> r_state == S_EMIT)
        else $error("hexadecimal item did not go straight to output");
`endif

endmodule

`default_nettype wire
